[rtl/core/delta_list_task_scheduler_assert.svh]
// Assertion macros for the delta-list task scheduler checker
`ifndef DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH
`define DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH

// property must hold on every clock once out of reset
`define DLTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen
`define DLTS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/dlts_pkg.sv]
// Types, codes and helpers shared by the delta-list task scheduler
`timescale 1ns / 1ps
`default_nettype none
package dlts_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ADD      = 2'd1,
        OP_DELETE   = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_NULL       = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NONE_READY = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] delta;
        logic [31:0] period;
        logic [15:0] ident;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    function automatic logic [15:0] next_id(input logic [15:0] last);
        logic [15:0] n;
        n = last + 16'd1;
        if (n == 16'd0)
        begin
            n = 16'd1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[rtl/core/dlts_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module dlts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/dlts_seq.sv]
// Sequencer: walks and shifts the delta list held in the slot RAM
`timescale 1ns / 1ps
`default_nettype none
module dlts_seq import dlts_pkg::*; #(
    parameter int MAX_TASKS = 16,
    localparam int CW = $clog2(MAX_TASKS + 1),
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    op,
    input  wire logic [15:0]   task_handle,
    input  wire logic [31:0]   start_delay,
    input  wire logic [31:0]   repeat_period,
    input  wire logic [15:0]   target_id,
    output logic               done,
    output logic [2:0]         status,
    output logic [15:0]        new_id,
    output logic [15:0]        fired_handle,
    output logic [15:0]        fired_id,
    output logic               fired,
    output logic [CW-1:0]      live_tasks,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output slot_t              mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  slot_t              mem_rdata
);

    seq_state_t  state_reg, state_next;
    op_t         op_reg;
    logic [15:0] handle_reg;
    logic [31:0] rem_reg;
    logic [31:0] period_reg;
    logic [15:0] target_reg;
    logic [31:0] fold_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] total_reg;
    logic [15:0] last_id_reg;
    status_t     status_reg;
    logic [15:0] new_id_reg;
    logic [15:0] fired_handle_reg;
    logic [15:0] fired_id_reg;
    logic        fired_reg;

    logic          accept;
    logic          full;
    logic          add_mode;
    logic          readd;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic          more_below;

    assign accept     = start && (state_reg == S_IDLE);
    assign full       = (total_reg == CW'(MAX_TASKS));
    assign add_mode   = (op_reg != OP_DELETE);
    assign readd      = (op_reg == OP_DISPATCH) && (period_reg != 32'd0);
    assign idx_inc    = idx_reg + CW'(1);
    assign idx_dec    = idx_reg - CW'(1);
    assign more_below = (idx_inc < total_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(op))
                        OP_TICK:     state_next = (total_reg == '0) ? S_DONE : S_HEAD_RD;
                        OP_ADD:      state_next = (task_handle == 16'd0 || full) ?
                                                  S_DONE : S_WALK_RD;
                        OP_DELETE:   state_next = (target_id == 16'd0) ? S_DONE : S_WALK_RD;
                        OP_DISPATCH: state_next = (total_reg == '0) ? S_DONE : S_HEAD_RD;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_HEAD_RD:  state_next = S_HEAD_CHK;
            S_HEAD_CHK:
            begin
                if (op_reg == OP_DISPATCH && mem_rdata.delta == 32'd0)
                    state_next = S_DN_RD;
                else
                    state_next = S_DONE;
            end
            S_WALK_RD:
            begin
                if (idx_reg == total_reg)
                    state_next = add_mode ? S_UP_RD : S_DONE;
                else
                    state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (add_mode)
                    state_next = (rem_reg < mem_rdata.delta) ? S_UP_RD : S_WALK_RD;
                else
                    state_next = (mem_rdata.ident == target_reg) ? S_DN_RD : S_WALK_RD;
            end
            S_UP_RD:    state_next = (idx_reg == pos_reg) ? S_INS_WR : S_UP_WR;
            S_UP_WR:    state_next = S_UP_RD;
            S_INS_WR:   state_next = S_DONE;
            S_DN_RD:
            begin
                if (more_below)
                    state_next = S_DN_WR;
                else
                    state_next = readd ? S_WALK_RD : S_DONE;
            end
            S_DN_WR:    state_next = S_DN_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory requests and port outputs
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            S_HEAD_RD:
            begin
                mem_re = 1'b1;
            end
            S_HEAD_CHK:
            begin
                if (op_reg == OP_TICK && mem_rdata.delta != 32'd0)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.delta = mem_rdata.delta - 32'd1;
                end
            end
            S_WALK_RD:
            begin
                mem_re    = (idx_reg != total_reg);
                mem_raddr = idx_reg[AW-1:0];
            end
            S_UP_RD:
            begin
                mem_re    = (idx_reg != pos_reg);
                mem_raddr = idx_dec[AW-1:0];
            end
            S_UP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                if (idx_dec == pos_reg)
                    mem_wdata.delta = mem_rdata.delta - rem_reg;
            end
            S_INS_WR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pos_reg[AW-1:0];
                mem_wdata.handle = handle_reg;
                mem_wdata.delta  = rem_reg;
                mem_wdata.period = period_reg;
                mem_wdata.ident  = new_id_reg;
            end
            S_DN_RD:
            begin
                mem_re    = more_below;
                mem_raddr = idx_inc[AW-1:0];
            end
            S_DN_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                if (idx_reg == pos_reg)
                    mem_wdata.delta = mem_rdata.delta + fold_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign status       = status_reg;
    assign new_id       = new_id_reg;
    assign fired_handle = fired_handle_reg;
    assign fired_id     = fired_id_reg;
    assign fired        = fired_reg;
    assign live_tasks   = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            last_id_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_INS_WR)
                total_reg <= total_reg + CW'(1);
            else if (state_reg == S_DN_RD && !more_below)
                total_reg <= total_reg - CW'(1);
            if ((accept && op_t'(op) == OP_ADD && task_handle != 16'd0 && !full) ||
                (state_reg == S_DN_RD && !more_below && readd))
                last_id_reg <= next_id(last_id_reg);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg           <= op_t'(op);
                    handle_reg       <= task_handle;
                    rem_reg          <= start_delay;
                    period_reg       <= repeat_period;
                    target_reg       <= target_id;
                    idx_reg          <= '0;
                    new_id_reg       <= 16'd0;
                    fired_handle_reg <= 16'd0;
                    fired_id_reg     <= 16'd0;
                    fired_reg        <= 1'b0;
                    status_reg       <= ST_OK;
                    case (op_t'(op))
                        OP_ADD:
                        begin
                            if (task_handle == 16'd0)
                                status_reg <= ST_NULL;
                            else if (full)
                                status_reg <= ST_FULL;
                            else
                                new_id_reg <= next_id(last_id_reg);
                        end
                        OP_DELETE:
                        begin
                            if (target_id == 16'd0)
                                status_reg <= ST_NOT_FOUND;
                        end
                        OP_DISPATCH:
                        begin
                            if (total_reg == '0)
                                status_reg <= ST_NONE_READY;
                        end
                        default:
                        begin
                            status_reg <= ST_OK;
                        end
                    endcase
                end
            end
            S_HEAD_CHK:
            begin
                if (op_reg == OP_DISPATCH)
                begin
                    if (mem_rdata.delta == 32'd0)
                    begin
                        fired_reg        <= 1'b1;
                        fired_handle_reg <= mem_rdata.handle;
                        fired_id_reg     <= mem_rdata.ident;
                        handle_reg       <= mem_rdata.handle;
                        period_reg       <= mem_rdata.period;
                        rem_reg          <= mem_rdata.period;
                        pos_reg          <= '0;
                        idx_reg          <= '0;
                        fold_reg         <= 32'd0;
                    end
                    else
                    begin
                        status_reg <= ST_NONE_READY;
                    end
                end
            end
            S_WALK_RD:
            begin
                if (idx_reg == total_reg)
                begin
                    if (add_mode)
                        pos_reg <= total_reg;
                    else
                        status_reg <= ST_NOT_FOUND;
                end
            end
            S_WALK_CHK:
            begin
                if (add_mode)
                begin
                    if (rem_reg < mem_rdata.delta)
                    begin
                        pos_reg <= idx_reg;
                        idx_reg <= total_reg;
                    end
                    else
                    begin
                        rem_reg <= rem_reg - mem_rdata.delta;
                        idx_reg <= idx_inc;
                    end
                end
                else if (mem_rdata.ident == target_reg)
                begin
                    pos_reg  <= idx_reg;
                    fold_reg <= mem_rdata.delta;
                end
                else
                begin
                    idx_reg <= idx_inc;
                end
            end
            S_UP_WR:
            begin
                idx_reg <= idx_dec;
            end
            S_DN_RD:
            begin
                if (!more_below && readd)
                begin
                    idx_reg    <= '0;
                    new_id_reg <= next_id(last_id_reg);
                end
            end
            S_DN_WR:
            begin
                idx_reg <= idx_inc;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/delta_list_task_scheduler.sv]
// Top level of the delta-list task scheduler
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Command channel: drive op and its operands with start high; the request is
//   taken at a rising edge where start is high and busy is low. busy stays high
//   until the result has been shown.
//   Result channel: done is high for exactly one cycle with status, new_id,
//   fired_handle, fired_id, fired and live_tasks valid. The receiver cannot
//   stall; the result must be taken in that cycle.
//   Steps per request: tick reads the head entry and decrements a nonzero delta;
//     rejected requests go straight to done;
//     add walks the list, then shifts each moved entry with a read and a write
//     before it writes the new entry; delete walks the list, then shifts up;
//     dispatch removes the head entry, then walks again for the re-add of a
//     periodic task.
//   One request is in work at a time; the slot RAM is walked one entry at
//   a time, with one read per walked entry and a read and a write per moved one.
//   Reset empties the list and clears the identifier counter; the slot RAM
//   is not cleared, only entries below the task count are read.
module delta_list_task_scheduler import dlts_pkg::*; #(
    parameter int MAX_TASKS = 16,
    localparam int CW = $clog2(MAX_TASKS + 1),
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    op,
    input  wire logic [15:0]   task_handle,
    input  wire logic [31:0]   start_delay,
    input  wire logic [31:0]   repeat_period,
    input  wire logic [15:0]   target_id,
    output logic               done,
    output logic [2:0]         status,
    output logic [15:0]        new_id,
    output logic [15:0]        fired_handle,
    output logic [15:0]        fired_id,
    output logic               fired,
    output logic [CW-1:0]      live_tasks
);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    slot_t         mem_rdata;

    dlts_seq #(
        .MAX_TASKS(MAX_TASKS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .task_handle  (task_handle),
        .start_delay  (start_delay),
        .repeat_period(repeat_period),
        .target_id    (target_id),
        .done         (done),
        .status       (status),
        .new_id       (new_id),
        .fired_handle (fired_handle),
        .fired_id     (fired_id),
        .fired        (fired),
        .live_tasks   (live_tasks),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    dlts_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_TASKS)
    ) u_slots (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

endmodule
`default_nettype wire

[rtl/core/dlts_chk.sv]
// Port-level checker for the delta-list task scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "delta_list_task_scheduler_assert.svh"
module dlts_chk import dlts_pkg::*; #(
    parameter int MAX_TASKS = 16,
    localparam int CW = $clog2(MAX_TASKS + 1)
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire logic [2:0]    status,
    input wire logic [15:0]   fired_id,
    input wire logic          fired,
    input wire logic [CW-1:0] live_tasks
);

    `DLTS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
    `DLTS_ASSERT(a_done_once, done |=> (!done && !busy), "result not a single-cycle strobe")
    `DLTS_ASSERT(a_fired_ok, (done && fired) |-> (status == ST_OK && fired_id != 16'd0),
                 "dispatch result inconsistent")
    `DLTS_NEVER(a_count_range, live_tasks > CW'(MAX_TASKS), "task count above capacity")

endmodule

bind delta_list_task_scheduler dlts_chk #(.MAX_TASKS(MAX_TASKS)) u_dlts_chk (.*);
`default_nettype wire
